// ----- design/lsos_pkg.sv -----
package lsos_pkg;

  localparam int RANGE_W = 16;
  localparam int POS_W = 32;
  localparam int LIMIT_W = 31;
  localparam int OBJ_W = 8;
  localparam int OUT_IDX_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_OBJECTS = 3'd0;
  localparam cfg_idx_t CFG_GAP_THRESHOLD = 3'd1;
  localparam cfg_idx_t CFG_MIN_DISTANCE = 3'd2;
  localparam cfg_idx_t CFG_X_LIMIT = 3'd3;
  localparam cfg_idx_t CFG_Y_LIMIT = 3'd4;

  localparam logic [OBJ_W-1:0] RST_MAX_OBJECTS = 8'd16;
  localparam logic [RANGE_W-1:0] RST_GAP_THRESHOLD = 16'd90;
  localparam logic [RANGE_W-1:0] RST_MIN_DISTANCE = 16'd20;
  localparam logic [LIMIT_W-1:0] RST_X_LIMIT = 31'(1500 << 16);
  localparam logic [LIMIT_W-1:0] RST_Y_LIMIT = 31'(1000 << 16);

  localparam logic KIND_OBJECT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [OBJ_W-1:0] max_objects;
    logic [RANGE_W-1:0] gap_threshold;
    logic [RANGE_W-1:0] min_distance;
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic valid;
    logic last;
  } point_t;

  typedef struct packed {
    logic obj_v;
    logic sum_v;
    logic [OUT_IDX_W-1:0] start_index;
    logic [OUT_IDX_W-1:0] point_count;
    logic [OBJ_W-1:0] total;
  } report_t;

endpackage

// ----- design/lsos_in_if.sv -----
interface lsos_in_if;
  import lsos_pkg::*;

  logic valid;
  logic ready;
  logic [RANGE_W-1:0] range_mm;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic last_point;

  modport source (output valid, range_mm, pos_x, pos_y, last_point, input ready);
  modport sink (input valid, range_mm, pos_x, pos_y, last_point, output ready);
endinterface

// ----- design/lsos_out_if.sv -----
interface lsos_out_if;
  import lsos_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  logic [OUT_IDX_W-1:0] start_index;
  logic [OUT_IDX_W-1:0] point_count;
  logic [OBJ_W-1:0] object_total;
  logic last;

  modport source (output valid, kind, start_index, point_count, object_total, last,
                  input ready);
  modport sink (input valid, kind, start_index, point_count, object_total, last,
                output ready);
endinterface

// ----- design/lidar_scan_object_segmenter_core.sv -----
// a point is registered in the classify stage, and its results pass through the report queue and the output register
// throughput: one point per cycle while the report queue is not full; a final point of a scan that
// closes a reported object gives two results, the object report and then the scan summary
// the four-entry report queue lets the point side run on while the result side is stalled
// reset: synchronous, active low; clears the scan state and queue, loads register defaults
module lidar_scan_object_segmenter_core
  import lsos_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lsos_in_if.sink               in_pt,
  lsos_out_if.source            out_res,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_OBJECTS:   cfg_nxt.max_objects = cfg_wdata[OBJ_W-1:0];
        CFG_GAP_THRESHOLD: cfg_nxt.gap_threshold = cfg_wdata[RANGE_W-1:0];
        CFG_MIN_DISTANCE:  cfg_nxt.min_distance = cfg_wdata[RANGE_W-1:0];
        CFG_X_LIMIT:       cfg_nxt.x_limit = cfg_wdata[LIMIT_W-1:0];
        CFG_Y_LIMIT:       cfg_nxt.y_limit = cfg_wdata[LIMIT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_objects <= RST_MAX_OBJECTS;
      cfg_r.gap_threshold <= RST_GAP_THRESHOLD;
      cfg_r.min_distance <= RST_MIN_DISTANCE;
      cfg_r.x_limit <= RST_X_LIMIT;
      cfg_r.y_limit <= RST_Y_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic q_push, q_full, q_head_valid, q_pop;
  report_t q_data, q_head;

  lsos_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (in_pt),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  lsos_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  lsos_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_res    (out_res)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("report queue overflow");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("pop from empty report queue");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && (out_res.kind == KIND_SUMMARY)) |-> out_res.last)
    else $error("summary not marked last");

  a_object_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && (out_res.kind == KIND_OBJECT)) |-> (out_res.object_total != '0))
    else $error("object report with zero total");

endmodule

// ----- design/lsos_front.sv -----
module lsos_front
  import lsos_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  lsos_in_if.sink   in_pt,
  input  cfg_t      cfg,
  input  logic      q_full,
  output logic      q_push,
  output report_t   q_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);
  localparam logic [IDX_W-1:0] MIN_COUNT = IDX_W'(2);

  // classify stage
  logic [POS_W-1:0] mag_x, mag_y;
  point_t pt_new;
  point_t a_pt_r;
  logic a_valid_r, a_valid_nxt;
  logic accept, b_take;

  always_comb begin
    mag_x = in_pt.pos_x[POS_W-1] ? (POS_W'(0) - $unsigned(in_pt.pos_x))
                                 : $unsigned(in_pt.pos_x);
    mag_y = in_pt.pos_y[POS_W-1] ? (POS_W'(0) - $unsigned(in_pt.pos_y))
                                 : $unsigned(in_pt.pos_y);
    pt_new.range_mm = in_pt.range_mm;
    pt_new.last = in_pt.last_point;
    pt_new.valid = (in_pt.range_mm >= cfg.min_distance)
                && (mag_x <= {1'b0, cfg.x_limit})
                && (mag_y <= {1'b0, cfg.y_limit});
  end

  assign b_take = a_valid_r && !q_full;
  assign in_pt.ready = !a_valid_r || b_take;
  assign accept = in_pt.valid && in_pt.ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (b_take) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pt_r <= pt_new;
    end
  end

  // segment tracking stage
  logic [IDX_W-1:0] point_index_r, point_index_nxt;
  logic in_object_r, in_object_nxt;
  logic [IDX_W-1:0] object_first_r, object_first_nxt;
  logic [RANGE_W-1:0] previous_range_r, previous_range_nxt;
  logic [OBJ_W-1:0] objects_found_r, objects_found_nxt;
  logic capacity_full_r, capacity_full_nxt;

  logic final_pt, brk, close_obj, open_after;
  logic [RANGE_W-1:0] diff;
  logic [IDX_W-1:0] count;
  report_t rep;

  always_comb begin
    point_index_nxt = point_index_r;
    in_object_nxt = in_object_r;
    object_first_nxt = object_first_r;
    previous_range_nxt = previous_range_r;
    objects_found_nxt = objects_found_r;
    capacity_full_nxt = capacity_full_r;

    final_pt = a_pt_r.last || (point_index_r >= LAST_IDX);
    diff = (a_pt_r.range_mm >= previous_range_r) ? (a_pt_r.range_mm - previous_range_r)
                                                 : (previous_range_r - a_pt_r.range_mm);
    brk = !a_pt_r.valid || (diff >= cfg.gap_threshold);
    close_obj = in_object_r && (brk || final_pt);
    count = point_index_r - object_first_r;

    rep.obj_v = 1'b0;
    rep.sum_v = final_pt;
    rep.start_index = OUT_IDX_W'(object_first_r);
    rep.point_count = OUT_IDX_W'(count);
    rep.total = objects_found_r;

    if (in_object_r && !close_obj) begin
      previous_range_nxt = a_pt_r.range_mm;
    end
    if (close_obj) begin
      in_object_nxt = 1'b0;
      if ((count > MIN_COUNT) && !capacity_full_r) begin
        if (objects_found_r >= cfg.max_objects) begin
          capacity_full_nxt = 1'b1;
        end else begin
          objects_found_nxt = objects_found_r + OBJ_W'(1);
          rep.obj_v = 1'b1;
          rep.total = objects_found_nxt;
        end
      end
    end

    open_after = in_object_r && !close_obj;
    if (!open_after && a_pt_r.valid && !final_pt) begin
      in_object_nxt = 1'b1;
      object_first_nxt = point_index_r;
      previous_range_nxt = a_pt_r.range_mm;
    end

    if (final_pt) begin
      point_index_nxt = '0;
      in_object_nxt = 1'b0;
      object_first_nxt = '0;
      previous_range_nxt = '0;
      objects_found_nxt = '0;
      capacity_full_nxt = 1'b0;
    end else begin
      point_index_nxt = point_index_r + IDX_W'(1);
    end
  end

  assign q_push = b_take && (rep.obj_v || rep.sum_v);
  assign q_data = rep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_index_r <= '0;
      in_object_r <= 1'b0;
      object_first_r <= '0;
      previous_range_r <= '0;
      objects_found_r <= '0;
      capacity_full_r <= 1'b0;
    end else if (b_take) begin
      point_index_r <= point_index_nxt;
      in_object_r <= in_object_nxt;
      object_first_r <= object_first_nxt;
      previous_range_r <= previous_range_nxt;
      objects_found_r <= objects_found_nxt;
      capacity_full_r <= capacity_full_nxt;
    end
  end

endmodule

// ----- design/lsos_queue.sv -----
module lsos_queue
  import lsos_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  report_t push_data,
  output logic    full,
  output logic    head_valid,
  output report_t head,
  input  logic    pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  report_t entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0] count_r, count_nxt;

  assign full = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt = count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/lsos_report.sv -----
module lsos_report
  import lsos_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  report_t   head,
  output logic      pop,
  lsos_out_if.source out_res
);

  logic out_valid_r, out_valid_nxt;
  logic kind_r, kind_nxt;
  logic [OUT_IDX_W-1:0] start_index_r, start_index_nxt;
  logic [OUT_IDX_W-1:0] point_count_r, point_count_nxt;
  logic [OBJ_W-1:0] object_total_r, object_total_nxt;
  logic last_r, last_nxt;
  logic phase_r, phase_nxt;
  logic load, done_entry;

  assign load = head_valid && (!out_valid_r || out_res.ready);

  // object report first, then the summary of the same request
  always_comb begin
    if (head.obj_v && !phase_r) begin
      kind_nxt = KIND_OBJECT;
      start_index_nxt = head.start_index;
      point_count_nxt = head.point_count;
      last_nxt = !head.sum_v;
      done_entry = !head.sum_v;
    end else begin
      kind_nxt = KIND_SUMMARY;
      start_index_nxt = '0;
      point_count_nxt = '0;
      last_nxt = 1'b1;
      done_entry = 1'b1;
    end
    object_total_nxt = head.total;
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = !done_entry;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign pop = load && done_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      start_index_r <= start_index_nxt;
      point_count_r <= point_count_nxt;
      object_total_r <= object_total_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.kind = kind_r;
  assign out_res.start_index = start_index_r;
  assign out_res.point_count = point_count_r;
  assign out_res.object_total = object_total_r;
  assign out_res.last = last_r;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lsos_pkg::*;

  localparam int SCAN_MAX = 1024;
  localparam int RANDOM_POINTS = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 150;
  localparam cfg_idx_t CFG_SPARE_FIRST = 3'd5;
  localparam cfg_idx_t CFG_SPARE_LAST = 3'd7;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;
  localparam logic signed [POS_W-1:0] POS_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MOST_POS = 32'sh7FFF_FFFF;
  localparam cfg_t CFG_DEFAULTS = '{RST_MAX_OBJECTS, RST_GAP_THRESHOLD, RST_MIN_DISTANCE,
                                    RST_X_LIMIT, RST_Y_LIMIT};

  typedef struct packed {
    logic kind;
    logic [OUT_IDX_W-1:0] start_index;
    logic [OUT_IDX_W-1:0] point_count;
    logic [OBJ_W-1:0] object_total;
    logic last;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lsos_in_if in_pt ();
  lsos_out_if out_res ();

  lidar_scan_object_segmenter_core #(.MAX_POINTS(SCAN_MAX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_pt(in_pt),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // segmenter state as the block should hold it
  cfg_t seg_cfg;
  int unsigned scan_pos;
  logic in_obj;
  logic [OUT_IDX_W-1:0] obj_first;
  logic [RANGE_W-1:0] prev_range;
  logic [OBJ_W-1:0] obj_total;
  logic cap_full;
  seg_result_t pending_results[$];

  int err_count = 0;
  int points_sent = 0;
  int random_points = 0;
  int objects_seen = 0;
  int summaries_seen = 0;

  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  bit hold_req = 1'b0;
  int hold_len = 0;

  always #5 clk = ~clk;

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic string fmt_result(seg_result_t v);
    return $sformatf("kind=%0d start=%0d count=%0d total=%0d last=%0d",
                     v.kind, v.start_index, v.point_count, v.object_total, v.last);
  endfunction

  function automatic logic [POS_W-1:0] abs_pos(logic signed [POS_W-1:0] v);
    return v[POS_W-1] ? -v : v;
  endfunction

  function automatic void clear_scan();
    scan_pos = 0;
    in_obj = 1'b0;
    obj_first = '0;
    prev_range = '0;
    obj_total = '0;
    cap_full = 1'b0;
  endfunction

  function automatic void predict_point(logic [RANGE_W-1:0] r, logic signed [POS_W-1:0] px,
                                        logic signed [POS_W-1:0] py, logic lp);
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    logic [RANGE_W-1:0] diff;
    logic scan_end;
    logic ok;
    int unsigned p;
    seg_result_t one;
    seg_result_t res[$];
    ax = abs_pos(px);
    ay = abs_pos(py);
    p = scan_pos;
    scan_end = lp || (p >= SCAN_MAX - 1);
    ok = r >= seg_cfg.min_distance && ax <= {1'b0, seg_cfg.x_limit} &&
         ay <= {1'b0, seg_cfg.y_limit};
    if (in_obj) begin
      diff = (r >= prev_range) ? r - prev_range : prev_range - r;
      if (!ok || diff >= seg_cfg.gap_threshold || scan_end) begin
        in_obj = 1'b0;
        if (p - obj_first > 2 && !cap_full) begin
          if (obj_total >= seg_cfg.max_objects) begin
            cap_full = 1'b1;
          end else begin
            obj_total++;
            one = '{KIND_OBJECT, obj_first, OUT_IDX_W'(p - obj_first), obj_total, 1'b0};
            res.push_back(one);
          end
        end
      end else begin
        prev_range = r;
      end
    end
    if (!in_obj && ok && !scan_end) begin
      in_obj = 1'b1;
      obj_first = OUT_IDX_W'(p);
      prev_range = r;
    end
    if (scan_end) begin
      one = '{KIND_SUMMARY, '0, '0, obj_total, 1'b0};
      res.push_back(one);
      clear_scan();
    end else begin
      scan_pos = p + 1;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  function automatic logic signed [POS_W-1:0] coord_in(logic [LIMIT_W-1:0] lim);
    longint unsigned mag;
    mag = ($urandom_range(0, 15) == 0) ? lim : $urandom % (longint'(lim) + 1);
    return $urandom_range(0, 1) ? -POS_W'(mag) : POS_W'(mag);
  endfunction

  function automatic logic signed [POS_W-1:0] coord_out(logic [LIMIT_W-1:0] lim);
    longint unsigned mag;
    if (lim == LIMIT_TOP) return POS_MOST_NEG;
    mag = longint'(lim) + 1 + $urandom % (64'h8000_0000 - lim);
    return $urandom_range(0, 1) ? -POS_W'(mag) : POS_W'(mag);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    case ($urandom_range(0, 3))
      0: c.max_objects = OBJ_W'($urandom_range(0, 3));
      1: c.max_objects = 8'd255;
      default: c.max_objects = OBJ_W'($urandom_range(1, 20));
    endcase
    case ($urandom_range(0, 4))
      0: c.gap_threshold = RANGE_W'($urandom_range(1, 20));
      1: c.gap_threshold = RANGE_W'($urandom_range(20, 500));
      2: c.gap_threshold = RANGE_W'($urandom);
      3: c.gap_threshold = 16'hFFFF;
      default: c.gap_threshold = RST_GAP_THRESHOLD;
    endcase
    case ($urandom_range(0, 3))
      0: c.min_distance = '0;
      1: c.min_distance = RANGE_W'($urandom_range(1, 100));
      2: c.min_distance = RANGE_W'($urandom_range(100, 5000));
      default: c.min_distance = RANGE_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: c.x_limit = LIMIT_W'($urandom_range(1, 1 << 20));
      1: c.x_limit = RST_X_LIMIT;
      2: c.x_limit = LIMIT_W'($urandom);
      default: c.x_limit = LIMIT_TOP;
    endcase
    case ($urandom_range(0, 3))
      0: c.y_limit = LIMIT_W'($urandom_range(1, 1 << 20));
      1: c.y_limit = RST_Y_LIMIT;
      2: c.y_limit = LIMIT_W'($urandom);
      default: c.y_limit = LIMIT_TOP;
    endcase
    return c;
  endfunction

  task automatic send_point(logic [RANGE_W-1:0] r, logic signed [POS_W-1:0] px,
                            logic signed [POS_W-1:0] py, logic lp);
    int gap;
    gap = in_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.range_mm <= r;
    in_pt.pos_x <= px;
    in_pt.pos_y <= py;
    in_pt.last_point <= lp;
    do @(posedge clk); while (!in_pt.ready);
    predict_point(r, px, py, lp);
    points_sent++;
  endtask

  task automatic send_run(int n, logic [RANGE_W-1:0] r);
    repeat (n) send_point(r, '0, '0, 1'b0);
  endtask

  task automatic drain();
    int waited;
    in_pt.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      note_error($sformatf("mismatch: %0d expected results never came",
                           pending_results.size()));
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_MAX_OBJECTS: seg_cfg.max_objects = v[OBJ_W-1:0];
      CFG_GAP_THRESHOLD: seg_cfg.gap_threshold = v[RANGE_W-1:0];
      CFG_MIN_DISTANCE: seg_cfg.min_distance = v[RANGE_W-1:0];
      CFG_X_LIMIT: seg_cfg.x_limit = v[LIMIT_W-1:0];
      CFG_Y_LIMIT: seg_cfg.y_limit = v[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(cfg_t c);
    drain();
    write_reg(CFG_MAX_OBJECTS, CFG_DATA_W'(c.max_objects));
    write_reg(CFG_GAP_THRESHOLD, CFG_DATA_W'(c.gap_threshold));
    write_reg(CFG_MIN_DISTANCE, CFG_DATA_W'(c.min_distance));
    write_reg(CFG_X_LIMIT, CFG_DATA_W'(c.x_limit));
    write_reg(CFG_Y_LIMIT, CFG_DATA_W'(c.y_limit));
    cfg_we <= 1'b0;
  endtask

  task automatic test_defaults();
    send_point(16'd1000, '0, '0, 1'b0);
    send_point(16'd1089, '0, '0, 1'b0);
    send_point(16'd1000, '0, '0, 1'b0);
    send_point(16'd1000, POS_W'(RST_X_LIMIT), '0, 1'b0);
    send_point(16'd1000, '0, -POS_W'(RST_Y_LIMIT), 1'b0);
    send_point(16'd1090, '0, '0, 1'b0);
    send_point(16'd1090, POS_W'(RST_X_LIMIT) + 1, '0, 1'b0);
    send_point(16'd19, '0, '0, 1'b0);
    send_run(2, 16'd20);
    send_point(16'd20, '0, '0, 1'b1);
    send_run(3, 16'd500);
    send_point(16'd500, '0, '0, 1'b1);
    send_point(16'd1000, '0, '0, 1'b1);
  endtask

  task automatic test_extremes();
    load_config('{8'd255, 16'hFFFF, 16'd0, LIMIT_TOP, LIMIT_TOP});
    send_point(16'd0, POS_MOST_POS, POS_MOST_POS, 1'b0);
    send_point(16'hFFFF, '0, -POS_MOST_POS, 1'b0);
    send_point(16'hFFFF, '0, '0, 1'b0);
    send_point(16'd0, '0, '0, 1'b0);
    send_point(16'd1, '0, '0, 1'b0);
    send_point(16'd2, '0, '0, 1'b0);
    send_point(16'd3, POS_MOST_NEG, '0, 1'b0);
    send_point(16'd7, '0, POS_MOST_NEG, 1'b0);
    send_point(16'd100, '0, '0, 1'b1);
    // zero limits, top minimum distance, no capacity: only top-range points at the origin fit
    load_config('{8'd0, 16'd1, 16'hFFFF, '0, '0});
    send_run(4, 16'hFFFF);
    send_point(16'hFFFE, '0, '0, 1'b0);
    send_run(4, 16'hFFFF);
    send_point(16'hFFFF, 32'sd1, '0, 1'b0);
    send_point(16'hFFFF, '0, '0, 1'b1);
    send_point(16'hFFFF, '0, -32'sd1, 1'b1);
  endtask

  task automatic test_registers();
    load_config(CFG_DEFAULTS);
    @(posedge clk);
    write_reg(CFG_SPARE_FIRST, '1);
    write_reg(CFG_SPARE_LAST, '0);
    cfg_we <= 1'b0;
    send_run(4, 16'd300);
    send_point(16'd300, '0, '0, 1'b1);
    // zero gap: every point after an object start breaks it
    load_config('{8'd2, 16'd0, RST_MIN_DISTANCE, RST_X_LIMIT, RST_Y_LIMIT});
    send_run(5, 16'd400);
    send_point(16'd400, '0, '0, 1'b1);
    load_config('{8'd2, 16'd50, RST_MIN_DISTANCE, RST_X_LIMIT, RST_Y_LIMIT});
    repeat (4) begin
      send_run(3, 16'd600);
      send_point(16'd5, '0, '0, 1'b0);
    end
    send_point(16'd600, '0, '0, 1'b1);
    send_run(3, 16'd600);
    send_point(16'd600, '0, '0, 1'b1);
  endtask

  task automatic test_long_scans();
    load_config('{8'd255, RST_GAP_THRESHOLD, RST_MIN_DISTANCE, RST_X_LIMIT, RST_Y_LIMIT});
    in_idle = 1'b0;
    out_idle = 1'b0;
    // short objects first, then one long object closed by the scan length
    for (int i = 0; i < SCAN_MAX; i++) begin
      send_point((i < SCAN_MAX / 2 && i % 4 == 3) ? 16'd0 : 16'd1000, '0, '0, 1'b0);
    end
    send_run(3, 16'd2000);
    send_point(16'd2000, '0, '0, 1'b1);
    in_idle = 1'b1;
    out_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    load_config(CFG_DEFAULTS);
    in_idle = 1'b0;
    out_idle = 1'b0;
    hold_len = HOLD_CYCLES;
    hold_req = 1'b1;
    repeat (20) send_point(16'd800, '0, '0, 1'b1);
    repeat (6) begin
      send_run(3, 16'd800);
      send_point(16'd800, '0, '0, 1'b1);
    end
    drain();
    in_idle = 1'b1;
    out_idle = 1'b1;
  endtask

  task automatic run_random_scan(int len);
    int prev;
    int cand;
    int gap;
    int pick;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic lp;
    gap = int'(seg_cfg.gap_threshold);
    prev = $urandom_range(seg_cfg.min_distance, 16'hFFFF);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      px = coord_in(seg_cfg.x_limit);
      py = coord_in(seg_cfg.y_limit);
      lp = (i == len - 1);
      if (pick < 70) begin
        cand = prev + ($urandom_range(0, 1) ? 1 : -1) *
               (gap > 1 ? int'($urandom_range(0, gap - 1)) : 0);
        if (cand < int'(seg_cfg.min_distance)) cand = int'(seg_cfg.min_distance);
      end else if (pick < 80) begin
        cand = prev + ($urandom_range(0, 1) ? 1 : -1) * (gap + int'($urandom_range(0, 300)));
      end else if (pick < 88 && seg_cfg.min_distance > 0) begin
        cand = $urandom_range(0, seg_cfg.min_distance - 1);
      end else if (pick < 95) begin
        cand = prev;
        if ($urandom_range(0, 1)) px = coord_out(seg_cfg.x_limit);
        else py = coord_out(seg_cfg.y_limit);
      end else begin
        cand = $urandom_range(0, 16'hFFFF);
        px = $urandom;
        py = $urandom;
        lp = lp || ($urandom_range(0, 9) == 0);
      end
      if (cand < 0) cand = 0;
      if (cand > 16'hFFFF) cand = 16'hFFFF;
      send_point(RANGE_W'(cand), px, py, lp);
      random_points++;
      prev = cand;
    end
  endtask

  task automatic test_random();
    int scans;
    while (random_points < RANDOM_POINTS) begin
      load_config(rand_cfg());
      in_idle = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      scans = $urandom_range(3, 6);
      repeat (scans) begin
        run_random_scan(($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 30));
      end
    end
    in_idle = 1'b1;
    out_idle = 1'b1;
  endtask

  // result side: random stalls per request, plus one long hold on demand
  initial begin : result_sink
    int gap;
    out_res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_res.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = out_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!(out_res.valid && out_res.ready) && !hold_req);
    end
  end

  always @(posedge clk) begin : result_check
    seg_result_t got;
    seg_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got = '{out_res.kind, out_res.start_index, out_res.point_count,
              out_res.object_total, out_res.last};
      if (got.kind == KIND_SUMMARY) summaries_seen++;
      else objects_seen++;
      if (pending_results.size() == 0) begin
        note_error({"mismatch: result with none expected: ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          note_error({"mismatch: expected ", fmt_result(want), " got ", fmt_result(got)});
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAX_OBJECTS;
    cfg_wdata <= '0;
    in_pt.valid <= 1'b0;
    in_pt.range_mm <= '0;
    in_pt.pos_x <= '0;
    in_pt.pos_y <= '0;
    in_pt.last_point <= 1'b0;
    seg_cfg = CFG_DEFAULTS;
    clear_scan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_registers();
    test_long_scans();
    test_backpressure();
    test_random();
    drain();
    $display("tb: %0d scan points sent, %0d object reports and %0d scan summaries checked",
             points_sent, objects_seen, summaries_seen);
    $display("tb: register extremes, capacity, zero gap, an overlong scan and long stalls run");
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- lidar_scan_object_segmenter_core.f -----
design/lsos_pkg.sv
design/lsos_in_if.sv
design/lsos_out_if.sv
design/lsos_front.sv
design/lsos_queue.sv
design/lsos_report.sv
design/lidar_scan_object_segmenter_core.sv
test/tb.sv
